### src/pdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdh_pkg;

  // fixed-point constants
  localparam int HALF_TURN   = 46080;      // 180 degrees in 1/256 degree
  localparam int FULL_TURN   = 92160;      // 360 degrees in 1/256 degree
  localparam int WRAP_RECIP  = 11930464;   // floor(2^40 / FULL_TURN)
  localparam int WRAP_SHIFT  = 40;
  localparam int Q_W         = 9;          // turns quotient width
  localparam int SPEED_LIMIT = 6553600;    // 100 percent in 1/65536 percent
  localparam int MV_LIMIT    = 66000;
  localparam int TRAV_SHIFT  = 17;         // counts * dpc to 1/256 inch
  localparam int DRIVE_SHIFT = 16;         // 1/65536 percent * mv to mv
  localparam int ERR_MAX     = 8388607;
  localparam int ERR_MIN     = -8388608;
  localparam logic [5:0] BAND_MAX = 6'd63;

  // datapath widths
  localparam int MA_W  = 34;
  localparam int MB_W  = 25;
  localparam int P_W   = 51;
  localparam int ACC_W = 50;
  localparam int TV_W  = 36;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    RSN_RUN,
    RSN_SETTLED,
    RSN_TIMEOUT
  } reason_t;

  typedef enum logic [2:0] {
    REG_HEADING_GAIN,
    REG_DERIVATIVE_GAIN,
    REG_INTEGRAL_GAIN,
    REG_INTEGRAL_WINDOW,
    REG_SETTLE_BAND,
    REG_SETTLE_NEEDED,
    REG_DISTANCE_PER_COUNT,
    REG_MV_PER_PERCENT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_ANGLE,
    ST_ERR,
    ST_DECIDE,
    ST_WRAP,
    ST_ACC0,
    ST_ACC1,
    ST_ACC2,
    ST_SPEED,
    ST_LEFT,
    ST_DLEFT,
    ST_DRIGHT,
    ST_START,
    ST_IDLE,
    ST_FIN
  } step_t;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_CNT,
    MS_RECIP,
    MS_QFULL,
    MS_PROP,
    MS_INT,
    MS_DER,
    MS_HEAD,
    MS_LEFT,
    MS_RIGHT
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ANGLE,
    OP_ERR,
    OP_DECIDE,
    OP_WRAP,
    OP_DIFF,
    OP_SPEED,
    OP_LEFT,
    OP_RIGHT,
    OP_START,
    OP_IDLE,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    step_t    goto_step;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    dp_op_t   dp_op;
    logic     br_fin;
    logic     last;
  } ctl_t;

  typedef struct packed {
    logic [15:0] heading_gain;
    logic [15:0] derivative_gain;
    logic [15:0] integral_gain;
    logic [15:0] integral_window;
    logic [15:0] settle_band;
    logic [5:0]  settle_needed;
    logic [23:0] distance_per_count;
    logic [7:0]  mv_per_percent;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [23:0] target_distance;
    logic [15:0] timeout_ticks;
    logic [15:0] proportional_gain;
    logic [23:0] heading;
    logic [23:0] left_position;
    logic [23:0] right_position;
  } item_t;

  typedef struct packed {
    logic [17:0] left_drive_mv;
    logic [17:0] right_drive_mv;
    logic [23:0] distance_error;
    logic        done_res;
    reason_t     stop_reason;
  } res_t;

  typedef struct packed {
    logic moving;
    logic finish;
  } stat_t;

  // control store: one word per step
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{goto_step: ST_IDLE, mul_sel: MS_NONE, acc_op: ACC_HOLD, dp_op: OP_NONE,
          br_fin: 1'b0, last: 1'b0};
    unique case (s)
      ST_ANGLE: begin
        w.dp_op = OP_ANGLE;  w.mul_sel = MS_CNT;   w.goto_step = ST_ERR;
      end
      ST_ERR: begin
        w.dp_op = OP_ERR;    w.mul_sel = MS_RECIP; w.goto_step = ST_DECIDE;
      end
      ST_DECIDE: begin
        w.dp_op = OP_DECIDE; w.mul_sel = MS_QFULL; w.goto_step = ST_WRAP;
        w.br_fin = 1'b1;
      end
      ST_WRAP: begin
        w.dp_op = OP_WRAP;   w.mul_sel = MS_PROP;  w.goto_step = ST_ACC0;
      end
      ST_ACC0: begin
        w.acc_op = ACC_LOAD; w.mul_sel = MS_INT;   w.goto_step = ST_ACC1;
      end
      ST_ACC1: begin
        w.acc_op = ACC_ADD;  w.mul_sel = MS_DER;   w.goto_step = ST_ACC2;
      end
      ST_ACC2: begin
        w.acc_op = ACC_ADD;  w.mul_sel = MS_HEAD;  w.dp_op = OP_DIFF;
        w.goto_step = ST_SPEED;
      end
      ST_SPEED: begin
        w.dp_op = OP_SPEED;  w.goto_step = ST_LEFT;
      end
      ST_LEFT: begin
        w.mul_sel = MS_LEFT; w.goto_step = ST_DLEFT;
      end
      ST_DLEFT: begin
        w.dp_op = OP_LEFT;   w.mul_sel = MS_RIGHT; w.goto_step = ST_DRIGHT;
      end
      ST_DRIGHT: begin
        w.dp_op = OP_RIGHT;  w.last = 1'b1;
      end
      ST_START: begin
        w.dp_op = OP_START;  w.last = 1'b1;
      end
      ST_IDLE: begin
        w.dp_op = OP_IDLE;   w.last = 1'b1;
      end
      ST_FIN: begin
        w.dp_op = OP_FIN;    w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/pdh_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pdh_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld_item,
  input  pdh_pkg::item_t item_in,
  input  logic           go,
  input  pdh_pkg::ctl_t  ctl,
  input  pdh_pkg::cfg_t  cfg,
  output pdh_pkg::res_t  res,
  output pdh_pkg::stat_t stat
);

  localparam int MA_W = pdh_pkg::MA_W;
  localparam int MB_W = pdh_pkg::MB_W;
  localparam int P_W  = pdh_pkg::P_W;
  localparam int ACC_W = pdh_pkg::ACC_W;
  localparam int TV_W = pdh_pkg::TV_W;
  localparam int QLO  = pdh_pkg::WRAP_SHIFT;
  localparam int QHI  = pdh_pkg::WRAP_SHIFT + pdh_pkg::Q_W - 1;
  localparam logic [P_W:0] HALF17 = (P_W + 1)'(1) << (pdh_pkg::TRAV_SHIFT - 1);
  localparam logic [P_W:0] HALF16 = (P_W + 1)'(1) << (pdh_pkg::DRIVE_SHIFT - 1);

  // move state
  logic                  moving_r;
  pdh_pkg::reason_t      last_reason_r;
  logic [5:0]            band_r;
  logic [15:0]           tick_r;
  logic [15:0]           tick_lim_r;
  logic [15:0]           gain_r;
  logic signed [23:0]    target_r;
  logic signed [23:0]    held_r;
  logic signed [23:0]    lref_r;
  logic signed [23:0]    rref_r;
  logic signed [23:0]    prev_r;
  logic signed [24:0]    ediff_r;
  logic signed [31:0]    esum_r;

  // scratch registers
  pdh_pkg::item_t        it_r;
  logic signed [P_W-1:0] p_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [24:0]    e_r;
  logic                  neg_r;
  logic                  big_r;
  logic [24:0]           x_r;
  logic signed [23:0]    err_r;
  logic signed [16:0]    aerr_r;
  logic signed [23:0]    spd_r;
  logic signed [32:0]    asp_r;
  logic signed [17:0]    left_r;

  logic signed [23:0]    tgt_s, hd_s, lp_s, rp_s;
  logic signed [24:0]    ldelta, rdelta;
  logic signed [25:0]    counts;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MA_W+MB_W-1:0] prod;

  logic                  p_neg;
  logic [P_W-1:0]        p_mag;
  logic [P_W:0]          r17, r16;
  logic [P_W-pdh_pkg::TRAV_SHIFT:0]  trav_mag;
  logic [P_W-pdh_pkg::DRIVE_SHIFT:0] dmag;
  logic signed [TV_W-1:0] trav;
  logic signed [TV_W:0]  diff;
  logic signed [23:0]    err_sat;
  logic [16:0]           dlim;
  logic signed [17:0]    drive;

  logic signed [24:0]    e_nxt;
  logic [24:0]           mag_nxt;

  logic [23:0]           err_mag;
  logic                  in_band, in_win, tmo, settled;
  logic [5:0]            band_nxt;
  logic signed [32:0]    esum_sum;
  logic signed [31:0]    esum_sat;

  logic [24:0]           r0_full;
  logic [17:0]           r0;
  logic [16:0]           rr;
  logic signed [17:0]    res_abs;
  logic signed [16:0]    aerr_nxt;
  logic signed [23:0]    spd_nxt;

  assign tgt_s = $signed(it_r.target_distance);
  assign hd_s  = $signed(it_r.heading);
  assign lp_s  = $signed(it_r.left_position);
  assign rp_s  = $signed(it_r.right_position);

  // encoder travel since start
  assign ldelta = 25'(lp_s) - 25'(lref_r);
  assign rdelta = 25'(rp_s) - 25'(rref_r);
  assign counts = 26'(ldelta) + 26'(rdelta);

  // shared multiplier operand select
  always_comb begin
    unique case (ctl.mul_sel)
      pdh_pkg::MS_CNT: begin
        mul_a = MA_W'(counts);
        mul_b = MB_W'(cfg.distance_per_count);
      end
      pdh_pkg::MS_RECIP: begin
        mul_a = MA_W'(x_r);
        mul_b = MB_W'(pdh_pkg::WRAP_RECIP);
      end
      pdh_pkg::MS_QFULL: begin
        mul_a = MA_W'(p_r[QHI:QLO]);
        mul_b = MB_W'(pdh_pkg::FULL_TURN);
      end
      pdh_pkg::MS_PROP: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(gain_r);
      end
      pdh_pkg::MS_INT: begin
        mul_a = MA_W'(esum_r);
        mul_b = MB_W'(cfg.integral_gain);
      end
      pdh_pkg::MS_DER: begin
        mul_a = MA_W'(ediff_r);
        mul_b = MB_W'(cfg.derivative_gain);
      end
      pdh_pkg::MS_HEAD: begin
        mul_a = MA_W'(aerr_r);
        mul_b = MB_W'(cfg.heading_gain);
      end
      pdh_pkg::MS_LEFT: begin
        mul_a = MA_W'(spd_r) + MA_W'(asp_r);
        mul_b = MB_W'(cfg.mv_per_percent);
      end
      pdh_pkg::MS_RIGHT: begin
        mul_a = MA_W'(spd_r) - MA_W'(asp_r);
        mul_b = MB_W'(cfg.mv_per_percent);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // round-to-nearest scaling of the product, ties away from zero
  assign p_neg    = p_r[P_W-1];
  assign p_mag    = p_neg ? P_W'(-p_r) : P_W'(p_r);
  assign r17      = {1'b0, p_mag} + HALF17;
  assign r16      = {1'b0, p_mag} + HALF16;
  assign trav_mag = r17[P_W:pdh_pkg::TRAV_SHIFT];
  assign dmag     = r16[P_W:pdh_pkg::DRIVE_SHIFT];
  assign trav     = p_neg ? -$signed({1'b0, trav_mag}) : $signed({1'b0, trav_mag});

  // distance error, saturated to 24 bits
  assign diff = (TV_W + 1)'(target_r) - (TV_W + 1)'(trav);
  always_comb begin
    if (diff > (TV_W + 1)'(pdh_pkg::ERR_MAX)) begin
      err_sat = 24'(pdh_pkg::ERR_MAX);
    end else if (diff < (TV_W + 1)'(pdh_pkg::ERR_MIN)) begin
      err_sat = 24'(pdh_pkg::ERR_MIN);
    end else begin
      err_sat = 24'(diff);
    end
  end

  // drive in millivolts, saturated
  assign dlim  = (dmag > (P_W - pdh_pkg::DRIVE_SHIFT + 1)'(pdh_pkg::MV_LIMIT)) ?
                 17'(pdh_pkg::MV_LIMIT) : dmag[16:0];
  assign drive = p_neg ? $signed(-{1'b0, dlim}) : $signed({1'b0, dlim});

  // heading error magnitude for the wrap
  assign e_nxt   = 25'(held_r) - 25'(hd_s);
  assign mag_nxt = e_nxt[24] ? 25'(-e_nxt) : 25'(e_nxt);

  // band, timeout and integral window checks
  assign err_mag  = err_r[23] ? 24'(-err_r) : 24'(err_r);
  assign in_band  = err_mag < 24'(cfg.settle_band);
  assign in_win   = err_mag < 24'(cfg.integral_window);
  assign tmo      = tick_r >= tick_lim_r;
  assign band_nxt = in_band ? ((band_r == pdh_pkg::BAND_MAX) ? band_r : band_r + 6'd1)
                            : 6'd0;
  assign settled  = band_nxt > cfg.settle_needed;
  assign esum_sum = 33'(esum_r) + 33'(err_r);
  always_comb begin
    if (esum_sum > 33'sh0_7FFF_FFFF) begin
      esum_sat = 32'sh7FFF_FFFF;
    end else if (esum_sum < -33'sh0_8000_0000) begin
      esum_sat = -32'sh8000_0000;
    end else begin
      esum_sat = 32'(esum_sum);
    end
  end

  // remainder of the turn count, one correction step
  assign r0_full  = x_r - p_r[24:0];
  assign r0       = r0_full[17:0];
  assign rr       = (r0 >= 18'(pdh_pkg::FULL_TURN)) ? 17'(r0 - 18'(pdh_pkg::FULL_TURN))
                                                    : r0[16:0];
  assign res_abs  = $signed({1'b0, rr}) - 18'(pdh_pkg::HALF_TURN - 1);
  assign aerr_nxt = big_r ? 17'(neg_r ? -res_abs : res_abs) : 17'(e_r);

  // speed clamp to +-100 percent
  always_comb begin
    if (acc_r > ACC_W'(pdh_pkg::SPEED_LIMIT)) begin
      spd_nxt = 24'(pdh_pkg::SPEED_LIMIT);
    end else if (acc_r < -ACC_W'(pdh_pkg::SPEED_LIMIT)) begin
      spd_nxt = -24'(pdh_pkg::SPEED_LIMIT);
    end else begin
      spd_nxt = 24'(acc_r);
    end
  end

  // move state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r      <= 1'b0;
      last_reason_r <= pdh_pkg::RSN_RUN;
      band_r        <= '0;
      tick_r        <= '0;
      tick_lim_r    <= '0;
      gain_r        <= '0;
      target_r      <= '0;
      held_r        <= '0;
      lref_r        <= '0;
      rref_r        <= '0;
      prev_r        <= '0;
      ediff_r       <= '0;
      esum_r        <= '0;
    end else if (go) begin
      unique case (ctl.dp_op)
        pdh_pkg::OP_START: begin
          target_r   <= tgt_s;
          tick_lim_r <= it_r.timeout_ticks;
          gain_r     <= it_r.proportional_gain;
          held_r     <= hd_s;
          lref_r     <= lp_s;
          rref_r     <= rp_s;
          prev_r     <= tgt_s;
          ediff_r    <= '0;
          esum_r     <= '0;
          band_r     <= '0;
          tick_r     <= '0;
          moving_r   <= 1'b1;
        end
        pdh_pkg::OP_DECIDE: begin
          if (tmo) begin
            moving_r      <= 1'b0;
            last_reason_r <= pdh_pkg::RSN_TIMEOUT;
          end else begin
            tick_r <= tick_r + 16'd1;
            band_r <= band_nxt;
            if (settled) begin
              moving_r      <= 1'b0;
              last_reason_r <= pdh_pkg::RSN_SETTLED;
            end else if (in_win) begin
              esum_r <= esum_sat;
            end
          end
        end
        pdh_pkg::OP_DIFF: begin
          ediff_r <= 25'(err_r) - 25'(prev_r);
          prev_r  <= err_r;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ld_item) begin
      it_r <= item_in;
    end
    if (go) begin
      if (ctl.mul_sel != pdh_pkg::MS_NONE) begin
        p_r <= $signed(prod[P_W-1:0]);
      end
      unique case (ctl.acc_op)
        pdh_pkg::ACC_LOAD: acc_r <= ACC_W'(p_r);
        pdh_pkg::ACC_ADD:  acc_r <= acc_r + ACC_W'(p_r);
        default: ;
      endcase
      unique case (ctl.dp_op)
        pdh_pkg::OP_ANGLE: begin
          e_r   <= e_nxt;
          neg_r <= e_nxt[24];
          big_r <= mag_nxt > 25'(pdh_pkg::HALF_TURN);
          x_r   <= mag_nxt - 25'(pdh_pkg::HALF_TURN + 1);
        end
        pdh_pkg::OP_ERR:   err_r  <= err_sat;
        pdh_pkg::OP_WRAP:  aerr_r <= aerr_nxt;
        pdh_pkg::OP_SPEED: begin
          spd_r <= spd_nxt;
          asp_r <= $signed(p_r[32:0]);
        end
        pdh_pkg::OP_LEFT:  left_r <= drive;
        default: ;
      endcase
    end
  end

  // result of an emitting step
  always_comb begin
    res = '0;
    unique case (ctl.dp_op)
      pdh_pkg::OP_RIGHT: begin
        res.left_drive_mv  = left_r;
        res.right_drive_mv = drive;
        res.distance_error = err_r;
      end
      pdh_pkg::OP_START: begin
        res.distance_error = tgt_s;
      end
      pdh_pkg::OP_IDLE: begin
        res.done_res    = 1'b1;
        res.stop_reason = last_reason_r;
      end
      pdh_pkg::OP_FIN: begin
        res.distance_error = err_r;
        res.done_res       = 1'b1;
        res.stop_reason    = last_reason_r;
      end
      default: ;
    endcase
  end

  assign stat.moving = moving_r;
  assign stat.finish = (ctl.dp_op == pdh_pkg::OP_DECIDE) && (tmo || settled);

endmodule

`default_nettype wire

### src/pid_drive_with_heading_hold.sv
// a running sample runs angle, error, decide, wrap, the accumulate steps, speed and
//   the drive steps, and one that ends the move jumps from decide to finish; a start
//   or an idle sample runs only its own step. The 11-step program shares one multiplier;
//   a new transaction is taken while the last result waits, not while a program runs
// reset: synchronous active-low rst_n clears the move state (idle) and loads the
//   register defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module pid_drive_with_heading_hold (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_distance[23:0], timeout_ticks[39:24], proportional_gain[55:40],
  // heading[79:56], left_position[103:80], right_position[127:104]
  input  logic [127:0] in_tdata,
  // action[0]
  input  logic [0:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_drive_mv[17:0], right_drive_mv[35:18], distance_error[59:36],
  // done_res[60], stop_reason[62:61], zero[63]
  output logic [63:0]  out_tdata,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  pdh_pkg::cfg_t    cfg_r;
  pdh_pkg::item_t   item_in;
  pdh_pkg::ctl_t    ctl;
  pdh_pkg::res_t    res;
  pdh_pkg::stat_t   stat;
  pdh_pkg::step_t   step_r, step_nxt;
  pdh_pkg::res_t    out_res_r;
  pdh_pkg::reg_idx_t reg_idx;
  logic             busy_r, busy_nxt;
  logic             out_valid_r;
  logic             in_acc, out_free, go, cfg_wr;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = pdh_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heading_gain       <= 16'd640;
      cfg_r.derivative_gain    <= 16'd678;
      cfg_r.integral_gain      <= 16'd0;
      cfg_r.integral_window    <= 16'd256;
      cfg_r.settle_band        <= 16'd256;
      cfg_r.settle_needed      <= 6'd20;
      cfg_r.distance_per_count <= 24'd31365;
      cfg_r.mv_per_percent     <= 8'd120;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pdh_pkg::REG_HEADING_GAIN:       cfg_r.heading_gain       <= cfg_pwdata[15:0];
        pdh_pkg::REG_DERIVATIVE_GAIN:    cfg_r.derivative_gain    <= cfg_pwdata[15:0];
        pdh_pkg::REG_INTEGRAL_GAIN:      cfg_r.integral_gain      <= cfg_pwdata[15:0];
        pdh_pkg::REG_INTEGRAL_WINDOW:    cfg_r.integral_window    <= cfg_pwdata[15:0];
        pdh_pkg::REG_SETTLE_BAND:        cfg_r.settle_band        <= cfg_pwdata[15:0];
        pdh_pkg::REG_SETTLE_NEEDED:      cfg_r.settle_needed      <= cfg_pwdata[5:0];
        pdh_pkg::REG_DISTANCE_PER_COUNT: cfg_r.distance_per_count <= cfg_pwdata[23:0];
        pdh_pkg::REG_MV_PER_PERCENT:     cfg_r.mv_per_percent     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pdh_pkg::REG_HEADING_GAIN:       cfg_prdata = 32'(cfg_r.heading_gain);
      pdh_pkg::REG_DERIVATIVE_GAIN:    cfg_prdata = 32'(cfg_r.derivative_gain);
      pdh_pkg::REG_INTEGRAL_GAIN:      cfg_prdata = 32'(cfg_r.integral_gain);
      pdh_pkg::REG_INTEGRAL_WINDOW:    cfg_prdata = 32'(cfg_r.integral_window);
      pdh_pkg::REG_SETTLE_BAND:        cfg_prdata = 32'(cfg_r.settle_band);
      pdh_pkg::REG_SETTLE_NEEDED:      cfg_prdata = 32'(cfg_r.settle_needed);
      pdh_pkg::REG_DISTANCE_PER_COUNT: cfg_prdata = 32'(cfg_r.distance_per_count);
      pdh_pkg::REG_MV_PER_PERCENT:     cfg_prdata = 32'(cfg_r.mv_per_percent);
      default:                         cfg_prdata = '0;
    endcase
  end

  // input unpacking
  assign item_in.action            = in_tuser[0];
  assign item_in.target_distance   = in_tdata[23:0];
  assign item_in.timeout_ticks     = in_tdata[39:24];
  assign item_in.proportional_gain = in_tdata[55:40];
  assign item_in.heading           = in_tdata[79:56];
  assign item_in.left_position     = in_tdata[103:80];
  assign item_in.right_position    = in_tdata[127:104];

  // sequencer handshake
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign ctl       = pdh_pkg::ucode(step_r);
  assign go        = busy_r && (!ctl.last || out_free);

  // next step: dispatch on accept, conditional jump on finish, else advance or hold
  always_comb begin
    priority if (in_acc) begin
      if (item_in.action == pdh_pkg::ACT_START) begin
        step_nxt = pdh_pkg::ST_START;
      end else if (stat.moving) begin
        step_nxt = pdh_pkg::ST_ANGLE;
      end else begin
        step_nxt = pdh_pkg::ST_IDLE;
      end
    end else if (go && ctl.br_fin && stat.finish) begin
      step_nxt = pdh_pkg::ST_FIN;
    end else if (go && !ctl.last) begin
      step_nxt = ctl.goto_step;
    end else begin
      step_nxt = step_r;
    end
  end

  always_comb begin
    priority if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (go && ctl.last) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pdh_pkg::ST_IDLE;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  pdh_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_item (in_acc),
    .item_in (item_in),
    .go      (go),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .res     (res),
    .stat    (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl.last) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.stop_reason, out_res_r.done_res,
                       out_res_r.distance_error, out_res_r.right_drive_mv,
                       out_res_r.left_drive_mv};

  // checks
  a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    (go && ctl.last) |=> out_tvalid)
    else $error("emitting step did not present a result");

  a_reason_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.stop_reason != pdh_pkg::RSN_RUN) |-> out_res_r.done_res)
    else $error("stop reason without done");

  a_done_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.done_res) |->
      (out_res_r.left_drive_mv == '0 && out_res_r.right_drive_mv == '0))
    else $error("finished move with nonzero drive");

  a_stop_only_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(stat.moving) && $past(rst_n)) |-> $past(ctl.dp_op == pdh_pkg::OP_DECIDE))
    else $error("move ended outside the decide step");

endmodule

`default_nettype wire
